// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker module of the deque block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ped_pkg.sv =====
// Types and constants for the priority end deque.
// No dependencies; imported by the core, the slot RAM and the checker.
`default_nettype none

package ped_pkg;

    localparam int ID_W     = 16;
    localparam int PRI_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    // One stored slot: priority above id
    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [ID_W-1:0]  id;
    } t_entry;

    // Operation codes on the func field
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    // Threshold register value after reset
    localparam logic [PRI_W-1:0] THRESH_RESET = 3'd4;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/ped_slot_ram.sv =====
// Slot storage for the deque: one write port, two registered read ports.
// Depends on ped_pkg for the entry type.
`default_nettype none

module ped_slot_ram
    import ped_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire t_entry                   i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output t_entry                        o_rd_data_a,
    output t_entry                        o_rd_data_b
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;

    // Write one slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both ends; the data is registered and valid in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_end_deque_core.sv =====
// Priority end deque: ring buffer of id/priority entries held in a slot RAM.
// Each item passes two states: in S_IDLE the word is accepted and the slot RAM
// reads both ends; in S_EXEC the update and write-back are done. No new word
// is taken until the last has left S_EXEC. The result word is registered when
// S_EXEC commits; a stalled result word holds the execute cycle until taken.
// Reset (synchronous, active low): ends and count to zero, threshold to 4; the
// slot contents are left as they are and need no clearing pass.
`default_nettype none

module priority_end_deque_core
    import ped_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [PRI_W-1:0]    i_cfg_front_threshold,
    // input words
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_func,
    input  wire logic [ID_W-1:0]     i_entry_id,
    input  wire logic [PRI_W-1:0]    i_entry_priority,
    // result words
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [ID_W-1:0]          o_out_id,
    output logic [PRI_W-1:0]         o_out_priority,
    output logic [COUNT_W-1:0]       o_count,
    output logic                     o_full_res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] HELD_FULL = CNT_W'(DEPTH);

    t_state             r_state, n_state;
    logic [PRI_W-1:0]   r_thresh;
    logic               r_func;
    t_entry             r_entry;
    logic [IDX_W-1:0]   r_front, n_front;
    logic [IDX_W-1:0]   r_back, n_back;
    logic [CNT_W-1:0]   r_held, n_held;

    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    t_entry             r_pick, n_pick;
    logic [COUNT_W-1:0] r_count;
    logic               r_full;

    logic               accept;
    logic               out_free;
    logic               fire;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             rd_front;
    t_entry             rd_back;
    logic               is_full;
    logic               is_empty;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = (r_state == S_EXEC) && out_free;
    assign is_full     = (r_held == HELD_FULL);
    assign is_empty    = (r_held == '0);

    // Slot RAM; writes happen only in the execute cycle and reads only on
    // acceptance, so the two never touch the same cycle
    ped_slot_ram #(
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (r_entry),
        .i_rd_en     (accept),
        .i_rd_addr_a (r_front),
        .i_rd_addr_b (r_back),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_back)
    );

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_front_threshold;
        end
    end

    // Latch the accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func      <= i_func;
            r_entry.id  <= i_entry_id;
            r_entry.pri <= i_entry_priority;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and input stall
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Modify: new ends, count, write slot and result
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_held   = r_held;
        n_status = ST_INSERTED;
        n_pick   = '0;
        wr_en    = 1'b0;
        wr_addr  = r_back;
        if (r_func == FUNC_INSERT) begin
            if (is_full) begin
                n_status = ST_DROPPED;
            end else begin
                wr_en  = fire;
                n_held = r_held + CNT_W'(1);
                priority if (is_empty) begin
                    n_front = '0;
                    n_back  = '0;
                    wr_addr = '0;
                end else if (r_entry.pri >= r_thresh) begin
                    n_front = (r_front == '0) ? IDX_LAST : r_front - IDX_W'(1);
                    wr_addr = n_front;
                end else begin
                    n_back  = (r_back == IDX_LAST) ? '0 : r_back + IDX_W'(1);
                    wr_addr = n_back;
                end
            end
        end else begin
            if (is_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status = ST_REMOVED;
                n_held   = r_held - CNT_W'(1);
                // a tie goes to the front
                if (rd_front.pri >= rd_back.pri) begin
                    n_pick  = rd_front;
                    n_front = (r_front == IDX_LAST) ? '0 : r_front + IDX_W'(1);
                end else begin
                    n_pick = rd_back;
                    n_back = (r_back == '0) ? IDX_LAST : r_back - IDX_W'(1);
                end
            end
        end
    end

    // Commit ends and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_held  <= '0;
        end else if (fire) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_held  <= n_held;
        end
    end

    // Result valid: set on commit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status <= n_status;
            r_pick   <= n_pick;
            r_count  <= COUNT_W'(n_held);
            r_full   <= (n_held == HELD_FULL);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_id       = r_pick.id;
    assign o_out_priority = r_pick.pri;
    assign o_count        = r_count;
    assign o_full_res     = r_full;

endmodule

`default_nettype wire

// ===== hw/rtl/ped_checker.sv =====
// Port-level checks for the priority end deque, bound to the core.
// Depends on ped_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ped_port_checker
    import ped_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                o_in_stall,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [STATUS_W-1:0] o_status,
    input  wire logic [ID_W-1:0]     o_out_id,
    input  wire logic [PRI_W-1:0]    o_out_priority,
    input  wire logic [COUNT_W-1:0]  o_count,
    input  wire logic                o_full_res
);

    // Only a removal carries an entry
    `ASSERT_IMPLY(a_no_entry, i_clk, i_rst_n, o_out_valid && (o_status != ST_REMOVED), (o_out_id == '0) && (o_out_priority == '0), "entry fields set without a removal")

    // A dropped insert leaves the deque full
    `ASSERT_IMPLY(a_drop_full, i_clk, i_rst_n, o_out_valid && (o_status == ST_DROPPED), o_full_res, "insert dropped while not full")

    // A remove on empty reports an empty deque
    `ASSERT_IMPLY(a_empty_cnt, i_clk, i_rst_n, o_out_valid && (o_status == ST_EMPTY), (o_count == '0) && !o_full_res, "remove on empty with entries held")

    // One word in flight: stall straight after acceptance
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second word accepted while one is at work")

    // A stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_status) && $stable(o_out_id) && $stable(o_count), "stalled result changed")

endmodule

bind priority_end_deque_core ped_port_checker u_ped_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_out_id       (o_out_id),
    .o_out_priority (o_out_priority),
    .o_count        (o_count),
    .o_full_res     (o_full_res)
);

`default_nettype wire
